### hw/rtl/tlco_pkg.sv
// Shared types, constants and the 5x7 font for the text label chip overlay.
`timescale 1ns / 1ps
`default_nettype none

package tlco_pkg;

  localparam int unsigned CHIP_H   = 22;
  localparam int unsigned TEXT_PAD = 4;

  localparam logic [15:0] WHITE_PIX  = 16'hFFFF;
  localparam logic [15:0] SHADOW_PIX = 16'h2121;

  localparam logic [1:0] KIND_BG     = 2'd0;
  localparam logic [1:0] KIND_WHITE  = 2'd1;
  localparam logic [1:0] KIND_SHADOW = 2'd2;

  localparam logic [2:0] REG_CHARS_LO = 3'd0;
  localparam logic [2:0] REG_CHARS_HI = 3'd1;
  localparam logic [2:0] REG_LENGTH   = 3'd2;
  localparam logic [2:0] REG_ZONE_L   = 3'd3;
  localparam logic [2:0] REG_ZONE_T   = 3'd4;
  localparam logic [2:0] REG_ZONE_W   = 3'd5;
  localparam logic [2:0] REG_ZONE_H   = 3'd6;

  // five columns, column 0 first; bit 0 of a column is the top row
  typedef logic [0:4][7:0] glyph_t;

  // cell geometry of one chip-local point
  typedef struct packed {
    logic       ok;
    logic       border;
    logic       glyph_ok;
    logic [3:0] cell_idx;
    logic [7:0] gx;
    logic [3:0] gy;
  } pt_geo_t;

  // glyph column selection of one point
  typedef struct packed {
    logic       ok;
    logic       border;
    logic       glyph_ok;
    logic [7:0] ch;
    logic [2:0] col;
    logic [2:0] row;
  } pt_cell_t;

  function automatic glyph_t glyph(input logic [7:0] ch_raw);
    logic [7:0] c;
    glyph_t     g;
    c = ch_raw;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'd32;
    end
    case (c)
      8'h30: g = 40'h3E_51_49_45_3E;
      8'h31: g = 40'h00_42_7F_40_00;
      8'h32: g = 40'h42_61_51_49_46;
      8'h33: g = 40'h21_41_45_4B_31;
      8'h34: g = 40'h18_14_12_7F_10;
      8'h35: g = 40'h27_45_45_45_39;
      8'h36: g = 40'h3C_4A_49_49_30;
      8'h37: g = 40'h01_71_09_05_03;
      8'h38: g = 40'h36_49_49_49_36;
      8'h39: g = 40'h06_49_49_29_1E;
      8'h41: g = 40'h7E_11_11_11_7E;
      8'h42: g = 40'h7F_49_49_49_36;
      8'h43: g = 40'h3E_41_41_41_22;
      8'h44: g = 40'h7F_41_41_22_1C;
      8'h45: g = 40'h7F_49_49_49_41;
      8'h46: g = 40'h7F_09_09_09_01;
      8'h47: g = 40'h3E_41_49_49_7A;
      8'h48: g = 40'h7F_08_08_08_7F;
      8'h49: g = 40'h00_41_7F_41_00;
      8'h4A: g = 40'h20_40_41_3F_01;
      8'h4B: g = 40'h7F_08_14_22_41;
      8'h4C: g = 40'h7F_40_40_40_40;
      8'h4D: g = 40'h7F_02_0C_02_7F;
      8'h4E: g = 40'h7F_04_08_10_7F;
      8'h4F: g = 40'h3E_41_41_41_3E;
      8'h50: g = 40'h7F_09_09_09_06;
      8'h51: g = 40'h3E_41_51_21_5E;
      8'h52: g = 40'h7F_09_19_29_46;
      8'h53: g = 40'h46_49_49_49_31;
      8'h54: g = 40'h01_01_7F_01_01;
      8'h55: g = 40'h3F_40_40_40_3F;
      8'h56: g = 40'h1F_20_40_20_1F;
      8'h57: g = 40'h7F_20_18_20_7F;
      8'h58: g = 40'h63_14_08_14_63;
      8'h59: g = 40'h03_04_78_04_03;
      8'h5A: g = 40'h61_51_49_45_43;
      8'h5E: g = 40'h04_02_01_02_04; // caret
      8'h3C: g = 40'h08_14_22_41_00; // less-than
      8'h3E: g = 40'h00_41_22_14_08; // greater-than
      8'h2B: g = 40'h08_08_3E_08_08; // plus
      8'h2D: g = 40'h08_08_08_08_08; // minus
      8'h21: g = 40'h00_00_5F_00_00; // bang
      8'h2E: g = 40'h00_60_60_00_00; // period
      8'h3A: g = 40'h00_36_36_00_00; // colon
      8'h2F: g = 40'h20_10_08_04_02; // slash
      8'h5C: g = 40'h02_04_08_10_20; // backslash
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/text_label_chip_overlay_top.sv
// Text label chip overlay: six-stage pixel pipeline and configuration registers.
`timescale 1ns / 1ps
`default_nettype none

// Overlays one bordered text chip (2x-scaled 5x7 font) on a pixel stream.
// Input item on s_axis: pixel column, row and RGB565 background. Output item
// on m_axis: the composed pixel in tdata and its kind (background, white,
// shadow) in tuser. One result per item, in order.
// Configuration is a write-only register port (enable, index, 64-bit data);
// write it only while no item is in flight. Chip placement is re-derived into
// registers in the cycle after a write.
// Six stage registers, the first loads on the input accept edge. Throughput:
// one item per cycle while the output is taken; every stage has its own
// valid bit and a stage only holds when the stage after it is full and held,
// so bubbles close up under a stall. A held output keeps its data until taken;
// the block keeps accepting items until the pipeline is full. Cell index uses a
// constant reciprocal multiply in stage three, glyph lookup is a constant table
// in stage five.
// Reset clears the configuration registers to zero (empty label, chip off)
// and empties the pipeline.
module text_label_chip_overlay_top #(
  parameter int unsigned MAX_LABEL_CHARS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,   // pixel_x[11:0], pixel_y[23:12], background[39:24]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // pixel_out[15:0]
  output logic [1:0]  m_axis_tuser_o,   // pixel_kind[1:0]
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i
);

  // ---------------- configuration ----------------
  logic [63:0] chars_lo_q, chars_hi_q;
  logic [4:0]  length_q;
  logic [11:0] zone_l_q, zone_t_q, zone_w_q, zone_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_lo_q <= '0;
      chars_hi_q <= '0;
      length_q   <= '0;
      zone_l_q   <= '0;
      zone_t_q   <= '0;
      zone_w_q   <= '0;
      zone_h_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tlco_pkg::REG_CHARS_LO: chars_lo_q <= cfg_data_i;
        tlco_pkg::REG_CHARS_HI: chars_hi_q <= cfg_data_i;
        tlco_pkg::REG_LENGTH:   length_q   <= cfg_data_i[4:0];
        tlco_pkg::REG_ZONE_L:   zone_l_q   <= cfg_data_i[11:0];
        tlco_pkg::REG_ZONE_T:   zone_t_q   <= cfg_data_i[11:0];
        tlco_pkg::REG_ZONE_W:   zone_w_q   <= cfg_data_i[11:0];
        tlco_pkg::REG_ZONE_H:   zone_h_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // chip placement, derived from the registers
  logic [4:0]  n_d, n_q;
  logic [7:0]  w_d, w_q;
  logic [11:0] cx_d, cx_q, cy_d, cy_q;
  logic signed [12:0] dx, dy, hx, hy;
  logic signed [13:0] cxs, cys;

  always_comb begin
    n_d  = (length_q > 5'(MAX_LABEL_CHARS)) ? 5'(MAX_LABEL_CHARS) : length_q;
    w_d  = 8'({n_d, 3'b000}) + 8'({n_d, 2'b00}) + 8'd6;
    dx   = $signed({1'b0, zone_w_q}) - $signed({5'b0, w_d});
    dy   = $signed({1'b0, zone_h_q}) - $signed(13'(tlco_pkg::CHIP_H));
    // halve, truncating toward zero
    hx   = (dx + $signed({12'b0, dx[12]})) >>> 1;
    hy   = (dy + $signed({12'b0, dy[12]})) >>> 1;
    cxs  = $signed({{2{zone_l_q[11]}}, zone_l_q}) + $signed({hx[12], hx});
    cys  = $signed({{2{zone_t_q[11]}}, zone_t_q}) + $signed({hy[12], hy});
    cx_d = cxs[13] ? 12'd0 : cxs[11:0];
    cy_d = cys[13] ? 12'd0 : cys[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q  <= '0;
      w_q  <= '0;
      cx_q <= '0;
      cy_q <= '0;
    end else begin
      n_q  <= n_d;
      w_q  <= w_d;
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  logic [15:0][7:0] chars;
  assign chars = {chars_hi_q, chars_lo_q};

  // ---------------- pipeline control ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || m_axis_tready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // ---------------- stage 1: capture ----------------
  logic [11:0] px1_q, py1_q;
  logic [15:0] bg1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      px1_q <= s_axis_tdata_i[11:0];
      py1_q <= s_axis_tdata_i[23:12];
      bg1_q <= s_axis_tdata_i[39:24];
    end
  end

  // ---------------- stage 2: chip-local coordinates ----------------
  logic signed [12:0] lx, ly;
  logic               in_chip;
  logic [7:0]  lx2_q;
  logic [4:0]  ly2_q;
  logic        in_chip2_q;
  logic [15:0] bg2_q;

  always_comb begin
    lx = $signed({1'b0, px1_q}) - $signed({1'b0, cx_q});
    ly = $signed({1'b0, py1_q}) - $signed({1'b0, cy_q});
    in_chip = (n_q != 5'd0) && !lx[12] && !ly[12] &&
              (lx[11:0] < {4'b0, w_q}) && (ly[11:0] < 12'(tlco_pkg::CHIP_H));
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      lx2_q      <= lx[7:0];
      ly2_q      <= ly[4:0];
      in_chip2_q <= in_chip;
      bg2_q      <= bg1_q;
    end
  end

  // ---------------- stage 3: cell geometry of pixel and up-left neighbor ----
  function automatic tlco_pkg::pt_geo_t geo(input logic [7:0] x, input logic [4:0] y,
                                            input logic [7:0] w, input logic [4:0] n,
                                            input logic ok);
    tlco_pkg::pt_geo_t r;
    logic [8:0]  gx;
    logic [5:0]  gy;
    logic [15:0] prod;
    logic [4:0]  cell_idx;
    gx   = {1'b0, x} - 9'(tlco_pkg::TEXT_PAD);
    gy   = {1'b0, y} - 6'(tlco_pkg::TEXT_PAD);
    // gx / 12 for gx below 256
    prod = 16'(gx[7:0]) * 16'd171;
    cell_idx = prod[15:11];
    r.ok       = ok;
    r.border   = (x == 8'd0) || (y == 5'd0) || (x == w - 8'd1) ||
                 (y == 5'(tlco_pkg::CHIP_H - 1));
    r.glyph_ok = !gx[8] && !gy[5] && (gy[4:0] < 5'd14) && (cell_idx < n);
    r.cell_idx = cell_idx[3:0];
    r.gx       = gx[7:0];
    r.gy       = gy[3:0];
    return r;
  endfunction

  tlco_pkg::pt_geo_t a3_q, b3_q;
  logic        in_chip3_q;
  logic [15:0] bg3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      a3_q       <= geo(lx2_q, ly2_q, w_q, n_q, 1'b1);
      b3_q       <= geo(lx2_q - 8'd1, ly2_q - 5'd1, w_q, n_q,
                        (lx2_q != 8'd0) && (ly2_q != 5'd0));
      in_chip3_q <= in_chip2_q;
      bg3_q      <= bg2_q;
    end
  end

  // ---------------- stage 4: column within cell, character ----------------
  function automatic tlco_pkg::pt_cell_t sel(input tlco_pkg::pt_geo_t g,
                                             input logic [15:0][7:0] cs);
    tlco_pkg::pt_cell_t r;
    logic [7:0] off;
    off = g.gx - ({g.cell_idx, 3'b000} + {1'b0, g.cell_idx, 2'b00});
    r.ok       = g.ok;
    r.border   = g.border;
    r.glyph_ok = g.glyph_ok && (off < 8'd10);
    r.ch       = cs[g.cell_idx];
    r.col      = off[3:1];
    r.row      = g.gy[3:1];
    return r;
  endfunction

  tlco_pkg::pt_cell_t a4_q, b4_q;
  logic        in_chip4_q;
  logic [15:0] bg4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      a4_q       <= sel(a3_q, chars);
      b4_q       <= sel(b3_q, chars);
      in_chip4_q <= in_chip3_q;
      bg4_q      <= bg3_q;
    end
  end

  // ---------------- stage 5: font lookup ----------------
  function automatic logic lit(input tlco_pkg::pt_cell_t c);
    tlco_pkg::glyph_t g;
    logic [7:0]       colbits;
    g = tlco_pkg::glyph(c.ch);
    colbits = (c.col < 3'd5) ? g[c.col] : 8'h00;
    return c.ok && (c.border || (c.glyph_ok && colbits[c.row]));
  endfunction

  logic        wa5_q, wb5_q, in_chip5_q;
  logic [15:0] bg5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      wa5_q      <= lit(a4_q);
      wb5_q      <= lit(b4_q);
      in_chip5_q <= in_chip4_q;
      bg5_q      <= bg4_q;
    end
  end

  // ---------------- stage 6: compose, output register ----------------
  logic [15:0] pix6_q;
  logic [1:0]  kind6_q;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      if (in_chip5_q && wa5_q) begin
        pix6_q  <= tlco_pkg::WHITE_PIX;
        kind6_q <= tlco_pkg::KIND_WHITE;
      end else if (in_chip5_q && wb5_q) begin
        pix6_q  <= tlco_pkg::SHADOW_PIX;
        kind6_q <= tlco_pkg::KIND_SHADOW;
      end else begin
        pix6_q  <= bg5_q;
        kind6_q <= tlco_pkg::KIND_BG;
      end
    end
  end

  assign m_axis_tvalid_o = v6_q;
  assign m_axis_tdata_o  = pix6_q;
  assign m_axis_tuser_o  = kind6_q;

endmodule

`default_nettype wire
